FILE: rtl/dmc_pkg.sv
package dmc_pkg;

    localparam int RND_W     = 16;
    localparam int RND_CNT_W = 4;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 5;
    localparam int WALL_W    = 4;
    localparam int EV_W      = 2;
    localparam int OUT_W     = 32;
    localparam int OUT_PAD_W = OUT_W - (4 * POS_W + 2 * WALL_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;
    localparam logic [CFG_W-1:0]     GRID_RESET    = 6'd16;

    // wall bit positions
    localparam int W_LEFT   = 0;
    localparam int W_TOP    = 1;
    localparam int W_RIGHT  = 2;
    localparam int W_BOTTOM = 3;
    localparam logic [WALL_W-1:0] ALL_WALLS = 4'hF;

    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef enum logic [EV_W-1:0] {
        EV_STARTED   = 2'd0,
        EV_CARVED    = 2'd1,
        EV_BACKTRACK = 2'd2,
        EV_DONE      = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        DIR_TOP    = 2'd0,
        DIR_LEFT   = 2'd1,
        DIR_RIGHT  = 2'd2,
        DIR_BOTTOM = 2'd3
    } t_dir;

    typedef struct packed {
        logic                visited;
        logic [WALL_W-1:0]   walls;
    } t_cell;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_MOD_GO,
        S_MOD_WAIT,
        S_ST_WR,
        S_CARVE,
        S_CARVE2,
        S_BT_RD,
        S_BT_WAIT,
        S_BT_DATA,
        S_EMIT
    } t_state;

endpackage

FILE: rtl/dmc_ram.sv
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dmc_mod_unit.sv
module dmc_mod_unit #(
    parameter int DIV_W = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [dmc_pkg::RND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_rem
);

    import dmc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [RND_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [RND_W-1:0]     r_dq;
    logic [DIV_W-1:0]     r_dvs;

    logic [DIV_W:0]       trial;
    logic [DIV_W-1:0]     rem_nx;

    // restoring remainder, one dividend bit per cycle, MSB first
    always_comb begin
        trial = {r_rem, r_dq[RND_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            rem_nx = DIV_W'(trial - {1'b0, r_dvs});
        end else begin
            rem_nx = DIV_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + RND_CNT_W'(1);
                if (r_cnt == RND_CNT_W'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_dq  <= {r_dq[RND_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/dfs_maze_carver_unit.sv
// Channel   Direction  tdata                        tuser
// s_axis    in         random_word[15:0]            action (0 start, 1 step)
// m_axis    out        see o_m_axis_tdata comment   event_kind
// cfg       in         write: 0 grid_rows, 1 grid_cols (6-bit data, no read-back)
//
// After reset the cell memory is swept to "unvisited, four walls", one cell a
// cycle, with s_axis held not ready.
// Start: the same sweep, then the shared remainder unit picks the start row and
// the start cell is written. Step: five cell memory reads, plus the 16-step
// remainder unit on a carve, or a stack read and one more cell read on a backtrack.
// s_axis is ready only between items; a result waits in the output register
// while the next item is taken, and a stalled m_axis holds the following one.
module dfs_maze_carver_unit #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dmc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dmc_pkg::RND_W-1:0]     i_s_axis_tdata,  // random_word
    input  logic                          i_s_axis_tuser,  // action
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // from_row, from_col, to_row, to_col, from_walls, to_walls, exit_opened, zero pad
    output logic [dmc_pkg::OUT_W-1:0]     o_m_axis_tdata,
    output logic [dmc_pkg::EV_W-1:0]      o_m_axis_tuser   // event_kind
);

    import dmc_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int RC_W = $clog2(MAX_ROWS + 1);
    localparam int CC_W = $clog2(MAX_COLS + 1);
    localparam int D_W = (RC_W > 3) ? RC_W : 3;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int STK_W = ROW_W + COL_W;

    function automatic logic [RC_W-1:0] f_eff_rows(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return RC_W'(1);
        end else if (int'(v) > MAX_ROWS) begin
            return RC_W'(MAX_ROWS);
        end
        return RC_W'(v);
    endfunction

    function automatic logic [CC_W-1:0] f_eff_cols(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CC_W'(1);
        end else if (int'(v) > MAX_COLS) begin
            return CC_W'(MAX_COLS);
        end
        return CC_W'(v);
    endfunction

    function automatic logic [CELL_W-1:0] f_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
        return CELL_W'(CELL_W'(r) * CELL_W'(MAX_COLS) + CELL_W'(c));
    endfunction

    function automatic logic [WALL_W-1:0] f_wall(input t_dir d);
        logic [WALL_W-1:0] m;
        m = '0;
        unique case (d)
            DIR_TOP:    m[W_TOP]    = 1'b1;
            DIR_LEFT:   m[W_LEFT]   = 1'b1;
            DIR_RIGHT:  m[W_RIGHT]  = 1'b1;
            DIR_BOTTOM: m[W_BOTTOM] = 1'b1;
            default:    m = '0;
        endcase
        return m;
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_grid_rows, r_grid_cols;
    logic [RC_W-1:0]   rows_eff;
    logic [CC_W-1:0]   cols_eff;

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CELL_W-1:0] r_clr;
    logic              r_start_pend;
    logic [RND_W-1:0]  r_rnd;
    logic [2:0]        r_k;

    logic [WALL_W-1:0] r_cw;
    logic              r_cv;
    logic [3:0]        r_nv;
    logic [WALL_W-1:0] r_nw [4];
    logic [3:0]        r_mask;

    logic [ROW_W-1:0]  r_fr, r_tr;
    logic [COL_W-1:0]  r_fc, r_tc;
    logic [WALL_W-1:0] r_fw, r_tw;
    logic              r_exit;
    t_event            r_kind;

    logic              r_m_valid;
    logic [OUT_W-1:0]  r_m_data;
    t_event            r_m_user;

    logic              c_we;
    logic [CELL_W-1:0] c_waddr, c_raddr;
    t_cell             c_wdata, c_rdata;
    logic              s_we;
    logic [CELL_W-1:0] s_waddr, s_raddr;
    logic [STK_W-1:0]  s_wdata, s_rdata;

    logic              m_start, m_done;
    logic [D_W-1:0]    m_divisor, m_rem;

    logic [3:0]        in_nb;
    logic [3:0]        mask_c;
    logic [2:0]        found;
    logic [ROW_W-1:0]  nb_row [4];
    logic [COL_W-1:0]  nb_col [4];
    logic [CELL_W-1:0] cur_addr, rd_addr;
    logic [1:0]        rd_idx;
    t_dir              c_dir;
    logic [WALL_W-1:0] cw_new, nw_new;
    logic              exit_c;
    logic [ROW_W-1:0]  st_row;
    logic [ROW_W-1:0]  bt_row;
    logic [COL_W-1:0]  bt_col;
    logic              s_fire, out_free;

    assign rows_eff = f_eff_rows(r_grid_rows);
    assign cols_eff = f_eff_cols(r_grid_cols);
    assign cur_addr = f_addr(r_row, r_col);
    assign cnt_m1 = r_count - CNT_W'(1);
    assign st_row = m_rem[ROW_W-1:0];
    assign bt_row = s_rdata[STK_W-1:COL_W];
    assign bt_col = s_rdata[COL_W-1:0];
    assign found = 3'($countones(r_mask));
    assign mask_c = in_nb & ~r_nv;
    assign s_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;

    // neighbours in the order top, left, right, bottom
    always_comb begin
        in_nb[0] = (r_row != '0) && (int'(r_row) - 1 < int'(rows_eff))
                   && (int'(r_col) < int'(cols_eff));
        in_nb[1] = (r_col != '0) && (int'(r_col) - 1 < int'(cols_eff))
                   && (int'(r_row) < int'(rows_eff));
        in_nb[2] = (int'(r_col) + 1 < int'(cols_eff)) && (int'(r_row) < int'(rows_eff));
        in_nb[3] = (int'(r_row) + 1 < int'(rows_eff)) && (int'(r_col) < int'(cols_eff));
        nb_row[0] = r_row - ROW_W'(1);
        nb_col[0] = r_col;
        nb_row[1] = r_row;
        nb_col[1] = r_col - COL_W'(1);
        nb_row[2] = r_row;
        nb_col[2] = r_col + COL_W'(1);
        nb_row[3] = r_row + ROW_W'(1);
        nb_col[3] = r_col;
    end

    // read slot 0 is the current cell, slots 1..4 the neighbours
    always_comb begin
        rd_idx = 2'(r_k - 3'd1);
        rd_addr = cur_addr;
        if (r_k != 3'd0 && r_k < 3'd5 && in_nb[rd_idx]) begin
            rd_addr = f_addr(nb_row[rd_idx], nb_col[rd_idx]);
        end
    end

    // pick the m_rem-th candidate
    always_comb begin
        logic [1:0] seen;
        logic       hit;
        seen = '0;
        hit = 1'b0;
        c_dir = DIR_TOP;
        for (int i = 0; i < 4; i++) begin
            if (r_mask[i] && !hit) begin
                if (seen == m_rem[1:0]) begin
                    hit = 1'b1;
                    c_dir = t_dir'(2'(i));
                end
                seen = seen + 2'd1;
            end
        end
    end

    always_comb begin
        t_dir opp;
        unique case (c_dir)
            DIR_TOP:    opp = DIR_BOTTOM;
            DIR_LEFT:   opp = DIR_RIGHT;
            DIR_RIGHT:  opp = DIR_LEFT;
            DIR_BOTTOM: opp = DIR_TOP;
            default:    opp = DIR_TOP;
        endcase
        cw_new = r_cw & ~f_wall(c_dir);
        exit_c = (c_dir == DIR_LEFT || c_dir == DIR_RIGHT)
                 && (int'(nb_col[c_dir]) == int'(cols_eff) - 1);
        nw_new = r_nw[c_dir] & ~f_wall(opp);
        if (exit_c) begin
            nw_new[W_RIGHT] = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CELL_W'(CELLS - 1)) begin
                    n_state = r_start_pend ? S_MOD_GO : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    n_state = (i_s_axis_tuser == ACT_START) ? S_CLEAR : S_RD;
                end
            end
            S_RD: begin
                if (r_k == 3'd5) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_count == '0) begin
                    n_state = S_EMIT;
                end else if (mask_c != '0) begin
                    n_state = S_MOD_GO;
                end else begin
                    n_state = S_BT_RD;
                end
            end
            S_MOD_GO:   n_state = S_MOD_WAIT;
            S_MOD_WAIT: begin
                if (m_done) begin
                    n_state = r_start_pend ? S_ST_WR : S_CARVE;
                end
            end
            S_ST_WR:   n_state = S_EMIT;
            S_CARVE:   n_state = S_CARVE2;
            S_CARVE2:  n_state = S_EMIT;
            S_BT_RD:   n_state = S_BT_WAIT;
            S_BT_WAIT: n_state = S_BT_DATA;
            S_BT_DATA: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory and remainder unit controls
    always_comb begin
        c_we = 1'b0;
        c_waddr = cur_addr;
        c_wdata = '{visited: 1'b0, walls: ALL_WALLS};
        c_raddr = rd_addr;
        s_we = 1'b0;
        s_waddr = r_count[CELL_W-1:0];
        s_wdata = {nb_row[c_dir], nb_col[c_dir]};
        s_raddr = cnt_m1[CELL_W-1:0];
        m_start = 1'b0;
        m_divisor = r_start_pend ? D_W'(rows_eff) : D_W'(found);
        unique case (r_state)
            S_CLEAR: begin
                c_we = 1'b1;
                c_waddr = r_clr;
            end
            S_MOD_GO: m_start = 1'b1;
            S_ST_WR: begin
                c_we = 1'b1;
                c_waddr = f_addr(st_row, '0);
                c_wdata = '{visited: 1'b1, walls: ALL_WALLS & ~f_wall(DIR_LEFT)};
                s_we = 1'b1;
                s_waddr = '0;
                s_wdata = {st_row, COL_W'(0)};
            end
            S_CARVE: begin
                c_we = 1'b1;
                c_wdata = '{visited: r_cv, walls: cw_new};
                s_we = (r_count < CNT_W'(CELLS));
            end
            S_CARVE2: begin
                c_we = 1'b1;
                c_waddr = f_addr(r_tr, r_tc);
                c_wdata = '{visited: 1'b1, walls: r_tw};
            end
            S_BT_WAIT: c_raddr = f_addr(bt_row, bt_col);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_grid_rows  <= GRID_RESET;
            r_grid_cols  <= GRID_RESET;
            r_row        <= '0;
            r_col        <= '0;
            r_count      <= '0;
            r_clr        <= '0;
            r_start_pend <= 1'b0;
            r_k          <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                    CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_EMIT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + CELL_W'(1);
                S_IDLE: begin
                    if (s_fire) begin
                        r_k <= '0;
                        r_clr <= '0;
                        if (i_s_axis_tuser == ACT_START) begin
                            r_start_pend <= 1'b1;
                        end
                    end
                end
                S_RD: r_k <= r_k + 3'd1;
                S_ST_WR: begin
                    r_row        <= st_row;
                    r_col        <= '0;
                    r_count      <= CNT_W'(1);
                    r_start_pend <= 1'b0;
                end
                S_CARVE: begin
                    if (r_count < CNT_W'(CELLS)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                S_CARVE2: begin
                    r_row <= r_tr;
                    r_col <= r_tc;
                end
                S_BT_WAIT: begin
                    r_row   <= bt_row;
                    r_col   <= bt_col;
                    r_count <= cnt_m1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_rnd <= i_s_axis_tdata;
        end
        unique case (r_state)
            S_RD: begin
                unique case (r_k)
                    3'd1: begin
                        r_cv <= c_rdata.visited;
                        r_cw <= c_rdata.walls;
                    end
                    3'd2: begin
                        r_nv[0] <= c_rdata.visited;
                        r_nw[0] <= c_rdata.walls;
                    end
                    3'd3: begin
                        r_nv[1] <= c_rdata.visited;
                        r_nw[1] <= c_rdata.walls;
                    end
                    3'd4: begin
                        r_nv[2] <= c_rdata.visited;
                        r_nw[2] <= c_rdata.walls;
                    end
                    3'd5: begin
                        r_nv[3] <= c_rdata.visited;
                        r_nw[3] <= c_rdata.walls;
                    end
                    default: begin
                    end
                endcase
            end
            S_EVAL: begin
                r_mask <= mask_c;
                r_fr   <= r_row;
                r_fc   <= r_col;
                r_fw   <= r_cw;
                r_exit <= 1'b0;
                r_tr   <= r_row;
                r_tc   <= r_col;
                r_tw   <= r_cw;
                r_kind <= (r_count == '0) ? EV_DONE : EV_BACKTRACK;
            end
            S_ST_WR: begin
                r_kind <= EV_STARTED;
                r_fr   <= st_row;
                r_fc   <= '0;
                r_tr   <= st_row;
                r_tc   <= '0;
                r_fw   <= ALL_WALLS & ~f_wall(DIR_LEFT);
                r_tw   <= ALL_WALLS & ~f_wall(DIR_LEFT);
                r_exit <= 1'b0;
            end
            S_CARVE: begin
                r_kind <= EV_CARVED;
                r_fw   <= cw_new;
                r_tw   <= nw_new;
                r_tr   <= nb_row[c_dir];
                r_tc   <= nb_col[c_dir];
                r_exit <= exit_c;
            end
            S_BT_WAIT: begin
                r_tr <= bt_row;
                r_tc <= bt_col;
            end
            S_BT_DATA: r_tw <= c_rdata.walls;
            S_EMIT: begin
                if (out_free) begin
                    r_m_user <= r_kind;
                    r_m_data <= {OUT_PAD_W'(0), r_exit, r_tw, r_fw,
                                 POS_W'(r_tc), POS_W'(r_tr), POS_W'(r_fc), POS_W'(r_fr)};
                end
            end
            default: begin
            end
        endcase
    end

    dmc_ram #(
        .WIDTH ($bits(t_cell)),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    dmc_ram #(
        .WIDTH (STK_W),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    dmc_mod_unit #(
        .DIV_W (D_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (m_start),
        .i_dividend (r_rnd),
        .i_divisor  (m_divisor),
        .o_done     (m_done),
        .o_rem      (m_rem)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule
